[design/bhe_pkg.sv]
`default_nettype none

package bhe_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // command codes on the input beat
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_BUILD  = 3'd3,
    CMD_SORT   = 3'd4,
    CMD_CHECK  = 3'd5,
    CMD_READ   = 3'd6
  } cmd_t;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // configuration register indexes
  localparam logic REG_MIN_ORDER   = 1'b0;
  localparam logic REG_SIGNED_KEYS = 1'b1;

  // one datapath operation per cycle, issued by the controller
  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_ACCEPT,
    UOP_SET_FULL,
    UOP_SET_EMPTY,
    UOP_SET_RANGE,
    UOP_APPEND,
    UOP_PUSH_INIT,
    UOP_PUT,
    UOP_LIFT_RD,
    UOP_LIFT_MOVE,
    UOP_RD_ROOT,
    UOP_POP_ROOT,
    UOP_POP_LAST,
    UOP_SINK_RDL,
    UOP_SINK_RDR,
    UOP_SINK_LEFT,
    UOP_SINK_SEL,
    UOP_SINK_MOVE,
    UOP_BUILD_INIT,
    UOP_BUILD_RD,
    UOP_TAKE_CUR,
    UOP_SORT_INIT,
    UOP_SORT_A,
    UOP_SORT_B,
    UOP_CHK_INIT,
    UOP_CHK_RDP,
    UOP_CHK_RDC,
    UOP_CHK_HIT,
    UOP_CHK_NEXT,
    UOP_RD_IDX,
    UOP_READ_TAKE,
    UOP_PUBLISH
  } uop_t;

  // datapath flags seen by the controller
  typedef struct packed {
    logic full;
    logic count_zero;
    logic last_one;
    logic idx_bad;
    logic pos_zero;
    logic left_out;
    logic right_in;
    logic lift_go;
    logic sink_go;
    logic iter_zero;
    logic iter_le1;
    logic chk_done;
    logic chk_hit;
  } dp_status_t;

endpackage

`default_nettype wire

[design/bhe_datapath.sv]
`default_nettype none

module bhe_datapath #(
  parameter int CAPACITY  = bhe_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = bhe_pkg::KEY_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bhe_pkg::uop_t      uop,
  output bhe_pkg::dp_status_t     st,
  input  wire logic [31:0]        key,
  input  wire logic [5:0]         index,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic               cfg_data,
  output logic [31:0]             value,
  output logic [6:0]              order_break,
  output logic [6:0]              fill,
  output logic [1:0]              status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;
  localparam int XW = (CW > 6) ? CW : 6;

  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] mem_q;

  logic                 min_order;
  logic                 signed_keys;
  logic [CW-1:0]        count;
  logic [AW-1:0]        pos;
  logic [CW-1:0]        len;
  logic [CW-1:0]        iter;
  logic [KEY_WIDTH-1:0] cur;
  logic [KEY_WIDTH-1:0] tmp;
  logic                 pick_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [5:0]           idx_r;
  logic [KEY_WIDTH-1:0] wval;
  logic [CW-1:0]        wbrk;
  logic [1:0]           wstat;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  logic [LW-1:0]        l_x;
  logic [LW-1:0]        r_x;
  logic [LW-1:0]        len_x;
  logic [AW-1:0]        pos_parent;
  logic [CW-1:0]        iter_m1;
  logic [CW-1:0]        iter_parent;
  logic [CW-1:0]        count_m1;
  logic [AW-1:0]        pick_addr;

  // true when a ranks strictly below b under the current ordering
  function automatic logic below(input logic [KEY_WIDTH-1:0] a,
                                 input logic [KEY_WIDTH-1:0] b,
                                 input logic                 mo,
                                 input logic                 sk);
    logic [KEY_WIDTH-1:0] flip;
    logic [KEY_WIDTH-1:0] ax;
    logic [KEY_WIDTH-1:0] bx;
    flip = sk ? (KEY_WIDTH'(1) << (KEY_WIDTH - 1)) : '0;
    ax   = a ^ flip;
    bx   = b ^ flip;
    return mo ? (ax > bx) : (ax < bx);
  endfunction

  assign l_x         = LW'({pos, 1'b1});
  assign r_x         = l_x + LW'(1);
  assign len_x       = LW'(len);
  assign pos_parent  = (pos - AW'(1)) >> 1;
  assign iter_m1     = iter - CW'(1);
  assign iter_parent = iter_m1 >> 1;
  assign count_m1    = count - CW'(1);
  assign pick_addr   = pick_r ? r_x[AW-1:0] : l_x[AW-1:0];

  assign st.full       = (count == CW'(CAPACITY));
  assign st.count_zero = (count == '0);
  assign st.last_one   = (count == CW'(1));
  assign st.idx_bad    = (XW'(idx_r) >= XW'(count));
  assign st.pos_zero   = (pos == '0);
  assign st.left_out   = (l_x >= len_x);
  assign st.right_in   = (r_x < len_x);
  assign st.lift_go    = below(mem_q, cur, min_order, signed_keys);
  assign st.sink_go    = below(cur, tmp, min_order, signed_keys);
  assign st.iter_zero  = (iter == '0);
  assign st.iter_le1   = (iter <= CW'(1));
  assign st.chk_done   = (iter >= count);
  assign st.chk_hit    = below(tmp, mem_q, min_order, signed_keys);

  assign cfg_ready = 1'b1;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    case (uop)
      bhe_pkg::UOP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = count[AW-1:0];
        wr_data = key_r;
      end
      bhe_pkg::UOP_PUT: begin
        wr_en = 1'b1;
      end
      bhe_pkg::UOP_LIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = pos_parent;
      end
      bhe_pkg::UOP_LIFT_MOVE: begin
        wr_en   = 1'b1;
        wr_data = mem_q;
      end
      bhe_pkg::UOP_RD_ROOT: begin
        rd_en = 1'b1;
      end
      bhe_pkg::UOP_POP_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = count_m1[AW-1:0];
      end
      bhe_pkg::UOP_SINK_RDL: begin
        rd_en   = 1'b1;
        rd_addr = l_x[AW-1:0];
      end
      bhe_pkg::UOP_SINK_RDR: begin
        rd_en   = 1'b1;
        rd_addr = r_x[AW-1:0];
      end
      bhe_pkg::UOP_SINK_MOVE: begin
        wr_en   = 1'b1;
        wr_data = tmp;
      end
      bhe_pkg::UOP_BUILD_RD,
      bhe_pkg::UOP_SORT_A: begin
        rd_en   = 1'b1;
        rd_addr = iter_m1[AW-1:0];
      end
      bhe_pkg::UOP_SORT_B: begin
        wr_en   = 1'b1;
        wr_addr = iter_m1[AW-1:0];
        wr_data = tmp;
      end
      bhe_pkg::UOP_CHK_RDP: begin
        rd_en   = 1'b1;
        rd_addr = iter_parent[AW-1:0];
      end
      bhe_pkg::UOP_CHK_RDC: begin
        rd_en   = 1'b1;
        rd_addr = iter[AW-1:0];
      end
      bhe_pkg::UOP_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_r);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_order   <= 1'b0;
      signed_keys <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bhe_pkg::REG_MIN_ORDER:   min_order   <= cfg_data;
        bhe_pkg::REG_SIGNED_KEYS: signed_keys <= cfg_data;
        default: min_order <= min_order;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (uop)
        bhe_pkg::UOP_APPEND,
        bhe_pkg::UOP_PUSH_INIT: count <= count + CW'(1);
        bhe_pkg::UOP_POP_ROOT:  count <= count - CW'(1);
        default:                count <= count;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (uop)
      bhe_pkg::UOP_ACCEPT: begin
        key_r <= KEY_WIDTH'(key);
        idx_r <= index;
        wval  <= '0;
        wbrk  <= '0;
        wstat <= bhe_pkg::ST_OK;
      end
      bhe_pkg::UOP_SET_FULL:  wstat <= bhe_pkg::ST_FULL;
      bhe_pkg::UOP_SET_EMPTY: wstat <= bhe_pkg::ST_EMPTY;
      bhe_pkg::UOP_SET_RANGE: wstat <= bhe_pkg::ST_RANGE;
      bhe_pkg::UOP_PUSH_INIT: begin
        pos <= count[AW-1:0];
        cur <= key_r;
      end
      bhe_pkg::UOP_LIFT_MOVE: pos <= pos_parent;
      bhe_pkg::UOP_POP_ROOT:  wval <= mem_q;
      bhe_pkg::UOP_POP_LAST: begin
        cur <= mem_q;
        pos <= '0;
        len <= count;
      end
      bhe_pkg::UOP_SINK_RDR,
      bhe_pkg::UOP_SINK_LEFT: begin
        tmp    <= mem_q;
        pick_r <= 1'b0;
      end
      bhe_pkg::UOP_SINK_SEL: begin
        // right child wins only when the left ranks strictly below it
        if (below(tmp, mem_q, min_order, signed_keys)) begin
          tmp    <= mem_q;
          pick_r <= 1'b1;
        end
      end
      bhe_pkg::UOP_SINK_MOVE: pos <= pick_addr;
      bhe_pkg::UOP_BUILD_INIT: iter <= count >> 1;
      bhe_pkg::UOP_BUILD_RD: begin
        pos  <= iter_m1[AW-1:0];
        iter <= iter_m1;
        len  <= count;
      end
      bhe_pkg::UOP_TAKE_CUR: cur <= mem_q;
      bhe_pkg::UOP_SORT_INIT: iter <= count;
      bhe_pkg::UOP_SORT_A: tmp <= mem_q;
      bhe_pkg::UOP_SORT_B: begin
        cur  <= mem_q;
        pos  <= '0;
        len  <= iter_m1;
        iter <= iter_m1;
      end
      bhe_pkg::UOP_CHK_INIT: begin
        wbrk <= count;
        iter <= CW'(1);
      end
      bhe_pkg::UOP_CHK_RDC:   tmp  <= mem_q;
      bhe_pkg::UOP_CHK_HIT:   wbrk <= iter;
      bhe_pkg::UOP_CHK_NEXT:  iter <= iter + CW'(1);
      bhe_pkg::UOP_READ_TAKE: wval <= mem_q;
      bhe_pkg::UOP_PUBLISH: begin
        value       <= 32'(wval);
        order_break <= 7'(wbrk);
        fill        <= 7'(count);
        status      <= wstat;
      end
      default: begin
        tmp <= tmp;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/bhe_ctrl.sv]
`default_nettype none

module bhe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          command,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire bhe_pkg::dp_status_t st,
  output bhe_pkg::uop_t            uop
);

  typedef enum logic [19:0] {
    S_IDLE       = 20'h00001,
    S_START      = 20'h00002,
    S_LIFT_R     = 20'h00004,
    S_LIFT_C     = 20'h00008,
    S_POP_ROOT   = 20'h00010,
    S_POP_LAST   = 20'h00020,
    S_SINK_L     = 20'h00040,
    S_SINK_GL    = 20'h00080,
    S_SINK_GR    = 20'h00100,
    S_SINK_C     = 20'h00200,
    S_BUILD_LOOP = 20'h00400,
    S_BUILD_GET  = 20'h00800,
    S_SORT_LOOP  = 20'h01000,
    S_SORT_A     = 20'h02000,
    S_SORT_B     = 20'h04000,
    S_CHK_LOOP   = 20'h08000,
    S_CHK_P      = 20'h10000,
    S_CHK_C      = 20'h20000,
    S_READ_GET   = 20'h40000,
    S_FIN        = 20'h80000
  } state_t;

  state_t        state;
  state_t        state_next;
  state_t        sink_ret;
  bhe_pkg::cmd_t op;

  assign in_ready = (state == S_IDLE);

  // where a finished sift-down goes back to
  always_comb begin
    case (op)
      bhe_pkg::CMD_BUILD: sink_ret = S_BUILD_LOOP;
      bhe_pkg::CMD_SORT:  sink_ret = S_SORT_LOOP;
      default:            sink_ret = S_FIN;
    endcase
  end

  always_comb begin
    state_next = state;
    uop        = bhe_pkg::UOP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          uop        = bhe_pkg::UOP_ACCEPT;
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = S_FIN;
        case (op)
          bhe_pkg::CMD_PUSH: begin
            if (st.full) begin
              uop = bhe_pkg::UOP_SET_FULL;
            end else begin
              uop        = bhe_pkg::UOP_PUSH_INIT;
              state_next = S_LIFT_R;
            end
          end
          bhe_pkg::CMD_APPEND: begin
            uop = st.full ? bhe_pkg::UOP_SET_FULL : bhe_pkg::UOP_APPEND;
          end
          bhe_pkg::CMD_POP: begin
            if (st.count_zero) begin
              uop = bhe_pkg::UOP_SET_EMPTY;
            end else begin
              uop        = bhe_pkg::UOP_RD_ROOT;
              state_next = S_POP_ROOT;
            end
          end
          bhe_pkg::CMD_BUILD: begin
            uop        = bhe_pkg::UOP_BUILD_INIT;
            state_next = S_BUILD_LOOP;
          end
          bhe_pkg::CMD_SORT: begin
            uop        = bhe_pkg::UOP_SORT_INIT;
            state_next = S_SORT_LOOP;
          end
          bhe_pkg::CMD_CHECK: begin
            uop        = bhe_pkg::UOP_CHK_INIT;
            state_next = S_CHK_LOOP;
          end
          bhe_pkg::CMD_READ: begin
            if (st.idx_bad) begin
              uop = bhe_pkg::UOP_SET_RANGE;
            end else begin
              uop        = bhe_pkg::UOP_RD_IDX;
              state_next = S_READ_GET;
            end
          end
          default: begin
            uop = bhe_pkg::UOP_NONE;
          end
        endcase
      end
      S_LIFT_R: begin
        if (st.pos_zero) begin
          uop        = bhe_pkg::UOP_PUT;
          state_next = S_FIN;
        end else begin
          uop        = bhe_pkg::UOP_LIFT_RD;
          state_next = S_LIFT_C;
        end
      end
      S_LIFT_C: begin
        if (st.lift_go) begin
          uop        = bhe_pkg::UOP_LIFT_MOVE;
          state_next = S_LIFT_R;
        end else begin
          uop        = bhe_pkg::UOP_PUT;
          state_next = S_FIN;
        end
      end
      S_POP_ROOT: begin
        uop        = bhe_pkg::UOP_POP_ROOT;
        state_next = st.last_one ? S_FIN : S_POP_LAST;
      end
      S_POP_LAST: begin
        uop        = bhe_pkg::UOP_POP_LAST;
        state_next = S_SINK_L;
      end
      S_SINK_L: begin
        if (st.left_out) begin
          uop        = bhe_pkg::UOP_PUT;
          state_next = sink_ret;
        end else begin
          uop        = bhe_pkg::UOP_SINK_RDL;
          state_next = S_SINK_GL;
        end
      end
      S_SINK_GL: begin
        if (st.right_in) begin
          uop        = bhe_pkg::UOP_SINK_RDR;
          state_next = S_SINK_GR;
        end else begin
          uop        = bhe_pkg::UOP_SINK_LEFT;
          state_next = S_SINK_C;
        end
      end
      S_SINK_GR: begin
        uop        = bhe_pkg::UOP_SINK_SEL;
        state_next = S_SINK_C;
      end
      S_SINK_C: begin
        if (st.sink_go) begin
          uop        = bhe_pkg::UOP_SINK_MOVE;
          state_next = S_SINK_L;
        end else begin
          uop        = bhe_pkg::UOP_PUT;
          state_next = sink_ret;
        end
      end
      S_BUILD_LOOP: begin
        if (st.iter_zero) begin
          state_next = S_FIN;
        end else begin
          uop        = bhe_pkg::UOP_BUILD_RD;
          state_next = S_BUILD_GET;
        end
      end
      S_BUILD_GET: begin
        uop        = bhe_pkg::UOP_TAKE_CUR;
        state_next = S_SINK_L;
      end
      S_SORT_LOOP: begin
        if (st.iter_le1) begin
          state_next = S_FIN;
        end else begin
          uop        = bhe_pkg::UOP_RD_ROOT;
          state_next = S_SORT_A;
        end
      end
      S_SORT_A: begin
        uop        = bhe_pkg::UOP_SORT_A;
        state_next = S_SORT_B;
      end
      S_SORT_B: begin
        uop        = bhe_pkg::UOP_SORT_B;
        state_next = S_SINK_L;
      end
      S_CHK_LOOP: begin
        if (st.chk_done) begin
          state_next = S_FIN;
        end else begin
          uop        = bhe_pkg::UOP_CHK_RDP;
          state_next = S_CHK_P;
        end
      end
      S_CHK_P: begin
        uop        = bhe_pkg::UOP_CHK_RDC;
        state_next = S_CHK_C;
      end
      S_CHK_C: begin
        if (st.chk_hit) begin
          uop        = bhe_pkg::UOP_CHK_HIT;
          state_next = S_FIN;
        end else begin
          uop        = bhe_pkg::UOP_CHK_NEXT;
          state_next = S_CHK_LOOP;
        end
      end
      S_READ_GET: begin
        uop        = bhe_pkg::UOP_READ_TAKE;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          uop        = bhe_pkg::UOP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= bhe_pkg::CMD_PUSH;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (uop == bhe_pkg::UOP_ACCEPT) begin
        op <= bhe_pkg::cmd_t'(command);
      end
      if (uop == bhe_pkg::UOP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/binary_heap_engine_top.sv]
`default_nettype none

// Binary heap priority queue over one single-port-write, registered-read key
// memory, run by a sequencer that does at most one memory access per cycle.
// One command is in flight at a time; in_ready is high only between commands,
// while the previous result may still sit in the output register. Push lifts
// the new key one level at a time; pop takes the root, moves the last key to
// the root and sinks it one level at a time, unless it took the last key.
// Check inspects one index at a time. Build and sort run one sift-down per
// parent or per sorted key. Ordering (max or min, signed or unsigned keys) is
// to be set over the configuration port while the block is idle; the block
// itself does not enforce this.
module binary_heap_engine_top #(
  parameter int CAPACITY  = bhe_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = bhe_pkg::KEY_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] key,
  input  wire logic [5:0]  index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      value,
  output logic [6:0]       order_break,
  output logic [6:0]       fill,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);

  bhe_pkg::uop_t       uop;
  bhe_pkg::dp_status_t st;

  bhe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .uop       (uop)
  );

  bhe_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .uop         (uop),
    .st          (st),
    .key         (key),
    .index       (index),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .value       (value),
    .order_break (order_break),
    .fill        (fill),
    .status      (status)
  );

  // a taken command leaves the engine busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("engine ready right after taking a command");

  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bhe_pkg::ST_FULL |-> fill == 7'(CAPACITY))
    else $error("full status with room left");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bhe_pkg::ST_EMPTY |-> fill == 7'd0 && value == 32'd0)
    else $error("empty status with keys stored");

  a_fault_no_break: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bhe_pkg::ST_OK |-> order_break == 7'd0)
    else $error("order break reported on a failed command");

endmodule

`default_nettype wire
